FILE: sv/interval_pump_timer_with_display_top_macros.svh
// assertion macros used by the checker of the pump timer
`ifndef INTERVAL_PUMP_TIMER_WITH_DISPLAY_TOP_MACROS_SVH
`define INTERVAL_PUMP_TIMER_WITH_DISPLAY_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define IPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define IPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ipt_pkg.sv
`timescale 1ns / 1ps

package ipt_pkg;

  // index, duration, phase and tick widths
  localparam int unsigned IdxW = 6;
  localparam int unsigned DurW = 16;
  localparam int unsigned PhaseW = 17;
  localparam int unsigned TickW = 9;

  localparam logic [7:0] RepeatDelayReset = 8'd64;
  localparam logic [7:0] SegBlank = 8'h7F;
  localparam logic [7:0] SegDpMask = 8'h7F;
  localparam logic [7:0] SegAllOff = 8'hFF;

  // digit positions on the display
  localparam logic [1:0] DigOnTens = 2'd0;
  localparam logic [1:0] DigOnOnes = 2'd1;
  localparam logic [1:0] DigOffTens = 2'd2;
  localparam logic [1:0] DigOffOnes = 2'd3;

  // input word: one tick with its button levels
  typedef struct packed {
    logic force_on;
    logic on_down;
    logic on_up;
    logic off_down;
    logic off_up;
    logic pause_key;
  } ipt_in_t;

  // output word: one display step
  typedef struct packed {
    logic       pump_on;
    logic [7:0] segments_n;
    logic [1:0] digit_select;
  } ipt_out_t;

  // display control between the timer core and the digit decoder
  typedef struct packed {
    logic [1:0] sel;
    logic       pump;
    logic       blank;
  } ipt_disp_ctl_t;

  // log-scale duration table, indices past the end read the last entry
  function automatic logic [DurW-1:0] ipt_duration(input logic [IdxW-1:0] idx);
    logic [DurW-1:0] d;
    unique case (idx)
      6'd0:  d = 16'd0;
      6'd1:  d = 16'd1;
      6'd2:  d = 16'd2;
      6'd3:  d = 16'd3;
      6'd4:  d = 16'd4;
      6'd5:  d = 16'd6;
      6'd6:  d = 16'd7;
      6'd7:  d = 16'd10;
      6'd8:  d = 16'd13;
      6'd9:  d = 16'd18;
      6'd10: d = 16'd24;
      6'd11: d = 16'd32;
      6'd12: d = 16'd42;
      6'd13: d = 16'd56;
      6'd14: d = 16'd75;
      6'd15: d = 16'd100;
      6'd16: d = 16'd133;
      6'd17: d = 16'd177;
      6'd18: d = 16'd236;
      6'd19: d = 16'd315;
      6'd20: d = 16'd420;
      6'd21: d = 16'd561;
      6'd22: d = 16'd747;
      6'd23: d = 16'd997;
      6'd24: d = 16'd1329;
      6'd25: d = 16'd1772;
      6'd26: d = 16'd2362;
      6'd27: d = 16'd3150;
      6'd28: d = 16'd4199;
      6'd29: d = 16'd5599;
      6'd30: d = 16'd7466;
      6'd31: d = 16'd9954;
      6'd32: d = 16'd13272;
      6'd33: d = 16'd17696;
      6'd34: d = 16'd23595;
      6'd35: d = 16'd31460;
      6'd36: d = 16'd41946;
      6'd37: d = 16'd55928;
      default: d = 16'd65535;
    endcase
    return d;
  endfunction

  // tens digit of a six-bit index
  function automatic logic [2:0] ipt_tens(input logic [IdxW-1:0] idx);
    logic [2:0] t;
    priority if (idx >= 6'd60) t = 3'd6;
    else if (idx >= 6'd50) t = 3'd5;
    else if (idx >= 6'd40) t = 3'd4;
    else if (idx >= 6'd30) t = 3'd3;
    else if (idx >= 6'd20) t = 3'd2;
    else if (idx >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  // active-low seven-segment patterns
  function automatic logic [7:0] ipt_glyph(input logic [3:0] dig);
    logic [7:0] g;
    unique case (dig)
      4'd0: g = 8'hC0;
      4'd1: g = 8'hF9;
      4'd2: g = 8'hA4;
      4'd3: g = 8'hB0;
      4'd4: g = 8'h99;
      4'd5: g = 8'h92;
      4'd6: g = 8'h82;
      4'd7: g = 8'hF8;
      4'd8: g = 8'h80;
      4'd9: g = 8'h90;
      default: g = SegAllOff;
    endcase
    return g;
  endfunction

endpackage

FILE: sv/ipt_stream_if.sv
`timescale 1ns / 1ps

// valid/ready channel carrying one word of payload_t
interface ipt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ipt_display.sv
`timescale 1ns / 1ps

module ipt_display (
  input  logic [ipt_pkg::IdxW-1:0] on_idx_i,
  input  logic [ipt_pkg::IdxW-1:0] off_idx_i,
  input  ipt_pkg::ipt_disp_ctl_t   ctl_i,
  output logic [7:0]               seg_o
);

  logic [ipt_pkg::IdxW-1:0] idx;
  logic [2:0]               tens;
  logic [ipt_pkg::IdxW-1:0] tens_x10;
  logic [ipt_pkg::IdxW-1:0] ones_w;
  logic [3:0]               dig;
  logic [7:0]               seg;

  // pick the index for this digit and split it into tens and ones
  always_comb begin
    idx = (ctl_i.sel[1]) ? off_idx_i : on_idx_i;
    tens = ipt_pkg::ipt_tens(idx);
    tens_x10 = {3'b000, tens} * 6'd10;
    ones_w = idx - tens_x10;
    dig = (ctl_i.sel[0]) ? ones_w[3:0] : {1'b0, tens};
  end

  // glyph, decimal point on the last digit, blink blanking
  always_comb begin
    seg = ipt_pkg::ipt_glyph(dig);
    if (ctl_i.sel == ipt_pkg::DigOffOnes && ctl_i.pump) begin
      seg = seg & ipt_pkg::SegDpMask;
    end
    if (ctl_i.blank) begin
      seg = seg | ipt_pkg::SegBlank;
    end
    seg_o = seg;
  end

endmodule

FILE: sv/interval_pump_timer_with_display_top.sv
`timescale 1ns / 1ps
// an accepted tick word is stepped from the input register into the output register
// throughput: one tick word per cycle unless the output stalls; input register and
// output register let a new word in while the previous output waits
// reset (rst_ni low, asynchronous): both word registers empty, paused, on index 3,
// off index 38 (both clamped to LEVELS-1), counters zero, repeat delay 64
module interval_pump_timer_with_display_top #(
  parameter int unsigned LEVELS = 39
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  ipt_stream_if.sink   in_i,
  ipt_stream_if.source out_o
);

  localparam logic [ipt_pkg::IdxW-1:0] IdxMax = ipt_pkg::IdxW'(LEVELS - 1);
  localparam logic [ipt_pkg::IdxW-1:0] OnIdxReset = (LEVELS - 1 < 3) ? IdxMax : 6'd3;
  localparam logic [ipt_pkg::IdxW-1:0] OffIdxReset = (LEVELS - 1 < 38) ? IdxMax : 6'd38;

  // handshake and word registers
  logic                  s1_valid_q, s1_valid_d;
  ipt_pkg::ipt_in_t      s1_data_q;
  logic                  out_valid_q, out_valid_d;
  ipt_pkg::ipt_out_t     out_data_q, out_data_d;
  logic                  adv, step, in_fire;

  // timer state
  logic [7:0]                 delay_q;
  logic [ipt_pkg::IdxW-1:0]   on_idx_q, on_idx_d;
  logic [ipt_pkg::IdxW-1:0]   off_idx_q, off_idx_d;
  logic [ipt_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [ipt_pkg::TickW-1:0]  tick_q, tick_d;
  logic [1:0]                 digit_q, digit_d;
  logic [7:0]                 hold_q, hold_d;
  logic                       paused_q, paused_d;
  logic                       pkey_last_q, pkey_last_d;

  logic [ipt_pkg::DurW-1:0]   on_dur, off_dur;
  logic [ipt_pkg::PhaseW-1:0] span;
  logic                       pump;
  ipt_pkg::ipt_disp_ctl_t     disp_ctl;
  logic [7:0]                 seg;

  // flow control
  assign adv = !out_valid_q || out_o.ready;
  assign step = s1_valid_q && adv;
  assign in_i.ready = !s1_valid_q || adv;
  assign in_fire = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data = out_data_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // phase counter and pump decision
  always_comb begin
    tick_d = tick_q + 9'd1;
    on_dur = ipt_pkg::ipt_duration(on_idx_q);
    off_dur = ipt_pkg::ipt_duration(off_idx_q);
    span = {1'b0, on_dur} + {1'b0, off_dur};
    phase_d = (phase_q >= span) ? '0 : phase_q + 17'd1;
    pump = !paused_q && ((phase_d > {1'b0, off_dur}) || s1_data_q.force_on);
    digit_d = digit_q + 2'd1;
  end

  // display step uses the indices before this tick's buttons
  always_comb begin
    disp_ctl.sel = digit_q;
    disp_ctl.pump = pump;
    disp_ctl.blank = paused_q && tick_d[ipt_pkg::TickW-1];
  end

  ipt_display u_display (
    .on_idx_i  (on_idx_q),
    .off_idx_i (off_idx_q),
    .ctl_i     (disp_ctl),
    .seg_o     (seg)
  );

  always_comb begin
    out_data_d.pump_on = pump;
    out_data_d.segments_n = seg;
    out_data_d.digit_select = digit_q;
  end

  // buttons with repeat hold-off and pause toggle
  always_comb begin
    on_idx_d = on_idx_q;
    off_idx_d = off_idx_q;
    hold_d = hold_q;
    paused_d = paused_q;
    pkey_last_d = pkey_last_q;
    if (hold_q != 8'd0) begin
      hold_d = hold_q - 8'd1;
    end else begin
      if (s1_data_q.on_down) begin
        if (on_idx_d != '0) on_idx_d = on_idx_d - 6'd1;
        hold_d = delay_q;
      end
      if (s1_data_q.on_up) begin
        if (on_idx_d < IdxMax) on_idx_d = on_idx_d + 6'd1;
        hold_d = delay_q;
      end
      if (s1_data_q.off_down) begin
        if (off_idx_d != '0) off_idx_d = off_idx_d - 6'd1;
        hold_d = delay_q;
      end
      if (s1_data_q.off_up) begin
        if (off_idx_d < IdxMax) off_idx_d = off_idx_d + 6'd1;
        hold_d = delay_q;
      end
      if (s1_data_q.pause_key && !pkey_last_q) begin
        paused_d = !paused_q;
        hold_d = delay_q;
      end
      pkey_last_d = s1_data_q.pause_key;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      delay_q <= ipt_pkg::RepeatDelayReset;
      on_idx_q <= OnIdxReset;
      off_idx_q <= OffIdxReset;
      phase_q <= '0;
      tick_q <= '0;
      digit_q <= '0;
      hold_q <= '0;
      paused_q <= 1'b1;
      pkey_last_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      if (step) begin
        on_idx_q <= on_idx_d;
        off_idx_q <= off_idx_d;
        phase_q <= phase_d;
        tick_q <= tick_d;
        digit_q <= digit_d;
        hold_q <= hold_d;
        paused_q <= paused_d;
        pkey_last_q <= pkey_last_d;
      end
    end
  end

  // word registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_i.data;
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: sv/ipt_checker.sv
`timescale 1ns / 1ps
`include "interval_pump_timer_with_display_top_macros.svh"

module ipt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input ipt_pkg::ipt_out_t out_data_i
);

  // a stalled output word stays put
  `IPT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "output word changed while stalled")

  // the input side only stalls behind a stalled output
  `IPT_ASSERT_NOW(a_in_stall, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without output back-pressure")

  // decimal point only on the last digit and only with the pump on
  `IPT_ASSERT_NOW(a_dp_rule, out_valid_i && (out_data_i.digit_select != ipt_pkg::DigOffOnes || !out_data_i.pump_on), out_data_i.segments_n[7], "decimal point lit outside pump-on last digit")

endmodule

bind interval_pump_timer_with_display_top ipt_checker u_ipt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_LEVELS = 39;
  localparam int unsigned TOP_INDEX = NUM_LEVELS - 1;
  localparam int unsigned STALL_LIMIT = 1000;

  // tick lengths per index, log scale
  localparam logic [15:0] DURATIONS [39] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd7, 16'd10, 16'd13, 16'd18,
    16'd24, 16'd32, 16'd42, 16'd56, 16'd75, 16'd100, 16'd133, 16'd177, 16'd236,
    16'd315, 16'd420, 16'd561, 16'd747, 16'd997, 16'd1329, 16'd1772, 16'd2362,
    16'd3150, 16'd4199, 16'd5599, 16'd7466, 16'd9954, 16'd13272, 16'd17696,
    16'd23595, 16'd31460, 16'd41946, 16'd55928, 16'd65535
  };

  // active-low digit patterns 0..9
  localparam logic [7:0] GLYPHS [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = 8'd0;
  logic              drv_valid = 1'b0;
  ipt_pkg::ipt_in_t  drv_data = '0;
  logic              mon_ready = 1'b0;

  ipt_stream_if #(.payload_t(ipt_pkg::ipt_in_t)) tick_if ();
  ipt_stream_if #(.payload_t(ipt_pkg::ipt_out_t)) disp_if ();

  assign tick_if.valid = drv_valid;
  assign tick_if.data = drv_data;
  assign disp_if.ready = mon_ready;

  interval_pump_timer_with_display_top #(
    .LEVELS(NUM_LEVELS)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i(tick_if),
    .out_o(disp_if)
  );

  always #1 clk = ~clk;

  // timer state as the block should hold it
  logic [7:0]  hold_delay;
  logic [5:0]  on_idx;
  logic [5:0]  off_idx;
  logic [16:0] phase_cnt;
  logic [8:0]  tick_cnt;
  logic [1:0]  digit_pos;
  logic [7:0]  hold_cnt;
  logic        is_paused;
  logic        pause_prev;

  ipt_pkg::ipt_in_t  ticks_to_send [$];
  ipt_pkg::ipt_out_t display_words_due [$];

  int  errors = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  function automatic logic [16:0] duration_ticks(input logic [5:0] idx);
    if (idx > 6'd38) begin
      return {1'b0, DURATIONS[38]};
    end
    return {1'b0, DURATIONS[idx]};
  endfunction

  // one tick of the timer: counters, display digit, then buttons
  task automatic step_timer(input ipt_pkg::ipt_in_t t, output ipt_pkg::ipt_out_t w);
    logic [16:0] on_len;
    logic [16:0] off_len;
    logic [17:0] span;
    logic        pump;
    logic [7:0]  seg;
    logic [1:0]  sel;
    tick_cnt = tick_cnt + 9'd1;
    on_len = duration_ticks(on_idx);
    off_len = duration_ticks(off_idx);
    span = {1'b0, on_len} + {1'b0, off_len};
    if ({1'b0, phase_cnt} >= span) begin
      phase_cnt = '0;
    end else begin
      phase_cnt = phase_cnt + 17'd1;
    end
    pump = !is_paused && ((phase_cnt > off_len) || t.force_on);

    // digit shown uses indices from before this tick's buttons
    sel = digit_pos;
    case (sel)
      ipt_pkg::DigOnTens: seg = GLYPHS[(on_idx / 10) % 10];
      ipt_pkg::DigOnOnes: seg = GLYPHS[on_idx % 10];
      ipt_pkg::DigOffTens: seg = GLYPHS[(off_idx / 10) % 10];
      default: begin
        seg = GLYPHS[off_idx % 10];
        if (pump) seg = seg & 8'h7F;
      end
    endcase
    digit_pos = digit_pos + 2'd1;

    // blink while paused, decimal point untouched
    if (is_paused && tick_cnt[8]) seg = seg | 8'h7F;

    // buttons, gated by the repeat hold
    if (hold_cnt != 8'd0) begin
      hold_cnt = hold_cnt - 8'd1;
    end else begin
      if (t.on_down) begin
        if (on_idx > 6'd0) on_idx = on_idx - 6'd1;
        hold_cnt = hold_delay;
      end
      if (t.on_up) begin
        if (on_idx < TOP_INDEX) on_idx = on_idx + 6'd1;
        hold_cnt = hold_delay;
      end
      if (t.off_down) begin
        if (off_idx > 6'd0) off_idx = off_idx - 6'd1;
        hold_cnt = hold_delay;
      end
      if (t.off_up) begin
        if (off_idx < TOP_INDEX) off_idx = off_idx + 6'd1;
        hold_cnt = hold_delay;
      end
      if (t.pause_key && !pause_prev) begin
        is_paused = !is_paused;
        hold_cnt = hold_delay;
      end
      pause_prev = t.pause_key;
    end

    w.pump_on = pump;
    w.segments_n = seg;
    w.digit_select = sel;
  endtask

  // sender: one tick word at a time, random gaps
  always @(posedge clk) begin : drive_ticks
    logic              nxt_valid;
    ipt_pkg::ipt_in_t  nxt_data;
    ipt_pkg::ipt_out_t due;
    if (rst_n) begin
      nxt_valid = drv_valid;
      nxt_data = drv_data;
      if (drv_valid && tick_if.ready) begin
        step_timer(drv_data, due);
        display_words_due.push_back(due);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 12);
        end else if (ticks_to_send.size() > 0) begin
          nxt_data = ticks_to_send.pop_front();
          nxt_valid = 1'b1;
        end
      end
      drv_valid <= nxt_valid;
      drv_data <= nxt_data;
    end
  end

  // receiver: compare each display word, random stalls
  always @(posedge clk) begin : check_display
    ipt_pkg::ipt_out_t got;
    ipt_pkg::ipt_out_t want;
    if (rst_n) begin
      if (disp_if.valid && disp_if.ready) begin
        got = disp_if.data;
        if (display_words_due.size() == 0) begin
          $display("%0t ns: word with none expected, actual %h", $time, got);
          errors = errors + 1;
        end else begin
          want = display_words_due.pop_front();
          if (got.pump_on !== want.pump_on) begin
            $display("%0t ns: pump_on expected %0b actual %0b", $time,
                     want.pump_on, got.pump_on);
            errors = errors + 1;
          end
          if (got.segments_n !== want.segments_n) begin
            $display("%0t ns: segments_n expected %h actual %h", $time,
                     want.segments_n, got.segments_n);
            errors = errors + 1;
          end
          if (got.digit_select !== want.digit_select) begin
            $display("%0t ns: digit_select expected %0d actual %0d", $time,
                     want.digit_select, got.digit_select);
            errors = errors + 1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        mon_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 12);
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_if.valid && tick_if.ready) || (disp_if.valid && disp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // wait until nothing is queued, in flight or due
  task automatic settle();
    while (ticks_to_send.size() != 0 || drv_valid || display_words_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic program_delay(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hold_delay = v;
  endtask

  // a short user action: hold one button or both down buttons, let the timer run, or noise
  task automatic queue_episode(output int added);
    int               kind;
    int               len;
    int               pick;
    int               pause_at;
    bit               frc;
    ipt_pkg::ipt_in_t t;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      len = $urandom_range(1, 30);
      pick = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        t = '0;
        case (pick)
          0, 1: t.off_down = 1'b1;
          2: t.off_up = 1'b1;
          3: t.on_down = 1'b1;
          4: t.on_up = 1'b1;
          default: begin
            t.on_down = 1'b1;
            t.off_down = 1'b1;
          end
        endcase
        t.force_on = ($urandom_range(0, 7) == 0);
        ticks_to_send.push_back(t);
      end
    end else if (kind < 8) begin
      len = $urandom_range(10, 80);
      pause_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, len - 1)) : -1;
      frc = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        t = '0;
        if ($urandom_range(0, 15) == 0) frc = !frc;
        t.force_on = frc;
        t.pause_key = (pause_at >= 0) && (i >= pause_at) && (i < pause_at + 3);
        ticks_to_send.push_back(t);
      end
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        t = ipt_pkg::ipt_in_t'(6'($urandom_range(0, 63)));
        ticks_to_send.push_back(t);
      end
    end
    added = len;
  endtask

  // new delay, then two batches with a full drain between them
  task automatic run_phase(input logic [7:0] delay_val, input int count, input bit quiet);
    int queued;
    int n;
    settle();
    program_delay(delay_val);
    calm = quiet;
    queued = 0;
    while (queued < count / 2) begin
      queue_episode(n);
      queued = queued + n;
    end
    settle();
    while (queued < count) begin
      queue_episode(n);
      queued = queued + n;
    end
  endtask

  initial begin
    hold_delay = ipt_pkg::RepeatDelayReset;
    on_idx = 6'd3;
    off_idx = 6'd38;
    phase_cnt = '0;
    tick_cnt = '0;
    digit_pos = '0;
    hold_cnt = '0;
    is_paused = 1'b1;
    pause_prev = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bounds, opposite buttons, pause edges, force
    // bit order: force, on_down, on_up, off_down, off_up, pause
    program_delay(8'd0);
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000001));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b100000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b010000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b010000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b010000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b010000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b001000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b011000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000100));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000010));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000010));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000110));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b111111));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b100000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000001));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b100000));
    ticks_to_send.push_back(ipt_pkg::ipt_in_t'(6'b000000));

    // random phases over several repeat delays, the last one without idling
    run_phase(8'd0, 240, 1'b0);
    run_phase(8'd255, 120, 1'b0);
    run_phase(8'($urandom_range(1, 20)), 200, 1'b0);
    run_phase(8'($urandom_range(1, 6)), 200, 1'b1);

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0 && display_words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
